>>> rtl/core/mgof_pkg.sv
// Shared types and constants for the median-gated outlier filter.
package mgof_pkg;

    localparam int WINDOW_DEF = 10;
    localparam int SAMPLE_W   = 16;
    localparam int THR_W      = 15;
    localparam logic [THR_W-1:0] THR_RESET = 15'd2859;

    typedef struct packed {
        logic load;
        logic rank_step;
        logic commit;
    } mgof_cmd_t;

    typedef struct packed {
        logic full;
        logic out_free;
    } mgof_sts_t;

endpackage

>>> rtl/core/mgof_ctrl.sv
// Sequencer: accepts a sample, steps the rank pass once the window is full, then commits the result.
module mgof_ctrl
    import mgof_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  mgof_sts_t sts,
    output mgof_cmd_t cmd
);

    localparam int RW = $clog2(WINDOW);
    localparam logic [RW-1:0] RANK_LAST = RW'(WINDOW - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RANK   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [RW-1:0] rank_cnt_reg, rank_cnt_next;
    logic          accept;

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign cmd.load      = accept;
    assign cmd.rank_step = (state_reg == ST_RANK);
    assign cmd.commit    = (state_reg == ST_COMMIT) && sts.out_free;

    always_comb begin
        state_next    = state_reg;
        rank_cnt_next = rank_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                rank_cnt_next = '0;
                if (accept) begin
                    // nothing to rank until the window is full
                    state_next = sts.full ? ST_RANK : ST_COMMIT;
                end
            end
            ST_RANK: begin
                rank_cnt_next = rank_cnt_reg + RW'(1);
                if (rank_cnt_reg == RANK_LAST) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rank_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            rank_cnt_reg <= rank_cnt_next;
        end
    end

endmodule

>>> rtl/core/mgof_dp.sv
// Datapath: sample window, rank-based median search, band gate, output register.
module mgof_dp
    import mgof_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [THR_W-1:0]           cfg_wr_data,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_accepted,
    output logic signed [SAMPLE_W-1:0] m_held_value,
    input  mgof_cmd_t                  cmd,
    output mgof_sts_t                  sts
);

    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [CW-1:0] MED_RANK = CW'(WINDOW / 2);
    localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW);
    localparam int BW = SAMPLE_W + 2;

    logic signed [SAMPLE_W-1:0] window_reg  [WINDOW];
    logic signed [SAMPLE_W-1:0] scratch_reg [WINDOW];
    logic [CW-1:0]              fill_cnt_reg;
    logic signed [SAMPLE_W-1:0] last_good_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] median_reg;
    logic [THR_W-1:0]           thr_reg;
    logic                       m_valid_reg;
    logic                       m_accepted_reg;
    logic signed [SAMPLE_W-1:0] m_held_reg;

    logic                       full;
    logic signed [SAMPLE_W-1:0] cand;
    logic [CW-1:0]              lt_cnt;
    logic [CW-1:0]              le_cnt;
    logic                       rank_hit;
    logic signed [BW-1:0]       band_lo;
    logic signed [BW-1:0]       band_hi;
    logic signed [BW-1:0]       samp_ext;
    logic                       in_band;

    assign full         = (fill_cnt_reg == FULL_CNT);
    assign sts.full     = full;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_accepted   = m_accepted_reg;
    assign m_held_value = m_held_reg;

    // candidate rotates through scratch; counted against every window entry
    assign cand = scratch_reg[0];

    always_comb begin
        lt_cnt = '0;
        le_cnt = '0;
        for (int j = 0; j < WINDOW; j++) begin
            lt_cnt = lt_cnt + CW'(window_reg[j] <  cand);
            le_cnt = le_cnt + CW'(window_reg[j] <= cand);
        end
    end

    // candidate sits at sorted position MED_RANK when lt <= k < le
    assign rank_hit = (lt_cnt <= MED_RANK) && (MED_RANK < le_cnt);

    assign band_lo  = BW'(median_reg) - BW'({1'b0, thr_reg});
    assign band_hi  = BW'(median_reg) + BW'({1'b0, thr_reg});
    assign samp_ext = BW'(sample_reg);
    assign in_band  = (samp_ext > band_lo) && (samp_ext < band_hi);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= s_sample;
            for (int i = 0; i < WINDOW; i++) begin
                scratch_reg[i] <= window_reg[i];
            end
        end else if (cmd.rank_step) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
                scratch_reg[i] <= scratch_reg[i+1];
            end
            scratch_reg[WINDOW-1] <= scratch_reg[0];
            if (rank_hit) begin
                median_reg <= cand;
            end
        end
    end

    // Shifting in during fill leaves the same window as slot-indexed writes
    // once the window is full.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                window_reg[i] <= '0;
            end
            fill_cnt_reg  <= '0;
            last_good_reg <= '0;
        end else if (cmd.commit) begin
            if (!full || in_band) begin
                for (int i = 0; i < WINDOW - 1; i++) begin
                    window_reg[i] <= window_reg[i+1];
                end
                last_good_reg <= sample_reg;
            end
            window_reg[WINDOW-1] <= sample_reg;
            if (!full) begin
                fill_cnt_reg <= fill_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_accepted_reg <= full && in_band;
            m_held_reg     <= (!full || in_band) ? sample_reg : last_good_reg;
        end
    end

endmodule

>>> rtl/core/median_gated_outlier_filter.sv
// Top level of the median-gated outlier filter: controller plus datapath.
//
//   channel   direction  handshake               payload
//   s_        in         s_valid / s_ready       s_sample
//   m_        out        m_valid / m_ready       m_accepted, m_held_value
//   cfg_      in         cfg_wr_en (no wait)     cfg_wr_data (gate threshold)
//
// Once the window is full a transaction runs accept, one rank-count step per window
// entry, then commit; during fill it runs accept, then commit.
// The output register lets the next sample be accepted while a result waits;
// a commit stalls only while that register is still held by m_ready low.
// aresetn is synchronous; it clears the window, fill count, held value and
// restores the threshold to its default.
module median_gated_outlier_filter
    import mgof_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [THR_W-1:0]           cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_accepted,
    output logic signed [SAMPLE_W-1:0] m_held_value
);

    mgof_cmd_t cmd;
    mgof_sts_t sts;

    mgof_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mgof_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_accepted   (m_accepted),
        .m_held_value (m_held_value),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Testbench for the median-gated outlier filter: directed and random samples vs a predictor.
module tb
    import mgof_pkg::*;
();

    localparam int WIN           = WINDOW_DEF;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 2 * WIN + 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic    accepted;
        sample_t held_value;
    } gate_result_t;

    logic             aclk;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [THR_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    sample_t          s_sample    = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    logic             m_accepted;
    sample_t          m_held_value;

    // filter state as the block should hold it
    sample_t          win_q [WIN];
    int unsigned      fill_q;
    sample_t          held_q;
    logic [THR_W-1:0] thr_q;

    gate_result_t expected_out [$];
    int           err_cnt        = 0;
    int           src_idle_pct   = 0;
    int           sink_stall_pct = 0;
    bit           hold_req       = 1'b0;
    int           hold_left      = 0;

    median_gated_outlier_filter #(
        .WINDOW(WIN)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_accepted  (m_accepted),
        .m_held_value(m_held_value)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("median_gated_outlier_filter: mismatch");
        $finish;
    end

    function automatic sample_t clip(input int v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return sample_t'(v);
    endfunction

    function automatic sample_t window_median();
        sample_t srt [WIN];
        sample_t key;
        int      j;
        srt = win_q;
        for (int i = 1; i < WIN; i++) begin
            key = srt[i];
            j = i - 1;
            while (j >= 0 && srt[j] > key) begin
                srt[j + 1] = srt[j];
                j--;
            end
            srt[j + 1] = key;
        end
        return srt[WIN / 2];
    endfunction

    // advance the filter state by one sample and return its result
    function automatic gate_result_t gate_step(input sample_t s);
        int           med;
        int           thr;
        gate_result_t r;
        r.accepted = 1'b0;
        if (fill_q < WIN) begin
            win_q[fill_q] = s;
            fill_q++;
            held_q = s;
        end else begin
            med = window_median();
            thr = int'(thr_q);
            // 32-bit compare, band edges never wrap
            if (s > med - thr && s < med + thr) begin
                for (int i = 0; i < WIN - 1; i++) begin
                    win_q[i] = win_q[i + 1];
                end
                win_q[WIN - 1] = s;
                held_q = s;
                r.accepted = 1'b1;
            end else begin
                win_q[WIN - 1] = s;
            end
        end
        r.held_value = held_q;
        return r;
    endfunction

    function automatic sample_t pick_sample();
        int med;
        int t;
        int sel;
        med = window_median();
        t   = int'(thr_q);
        sel = $urandom_range(99);
        if (sel < 55) begin
            return clip(med + int'($urandom_range(2 * t + 4)) - t - 2);
        end else if (sel < 70) begin
            case ($urandom_range(3))
                0: return clip(med - t);
                1: return clip(med - t + 1);
                2: return clip(med + t - 1);
                default: return clip(med + t);
            endcase
        end else if (sel < 90) begin
            return sample_t'($urandom_range(65535));
        end
        return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    endfunction

    task automatic note_mismatch(input string what, input int exp_v, input int got_v);
        err_cnt++;
        $display("%0t: %s expected %0d actual %0d", $time, what, exp_v, got_v);
    endtask

    // valid is lowered only when idling, so back-to-back items keep it high
    task automatic send_sample(input sample_t s);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= s;
        do @(posedge aclk); while (!s_ready);
        expected_out = {expected_out, gate_step(s)};
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_out.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        thr_q = v;
    endtask

    // result checker
    always @(posedge aclk) begin
        gate_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_out.size() == 0) begin
                note_mismatch("unexpected transaction, held_value", 0, m_held_value);
            end else begin
                exp_r = expected_out.pop_front();
                if (m_accepted !== exp_r.accepted) begin
                    note_mismatch("accepted", exp_r.accepted, m_accepted);
                end
                if (m_held_value !== exp_r.held_value) begin
                    note_mismatch("held_value", exp_r.held_value, m_held_value);
                end
            end
        end
    end

    // receiver: random stalls, or a long hold when requested
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    task automatic test_fill();
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        send_sample(16'sd100);
        send_sample(-16'sd100);
        send_sample(16'sd8192);
    endtask

    // default threshold; both band edges are exclusive
    task automatic test_band_edges();
        send_sample(window_median());
        send_sample(clip(window_median() - int'(thr_q)));
        send_sample(clip(window_median() - int'(thr_q) + 1));
        send_sample(clip(window_median() + int'(thr_q) - 1));
        send_sample(clip(window_median() + int'(thr_q)));
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
    endtask

    // empty band: nothing is accepted
    task automatic test_zero_threshold();
        set_threshold('0);
        send_sample(window_median());
        send_sample(clip(window_median() + 1));
        send_sample(clip(window_median() - 1));
        send_sample(sample_t'($urandom_range(65535)));
    endtask

    // widest band, median driven onto each rail so the band spans past 16 bits
    task automatic test_rail_walk();
        set_threshold(15'h7FFF);
        repeat (12) send_sample(clip(window_median() - 32766));
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        repeat (12) send_sample(clip(window_median() + 32766));
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
    endtask

    task automatic test_backpressure();
        set_threshold(THR_RESET);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req = 1'b1;
        repeat (24) send_sample(pick_sample());
        // sender pauses until every result is out
        wait_drained();
        repeat (8) send_sample(pick_sample());
    endtask

    task automatic test_random_phase(input int n, input int src_pct, input int sink_pct,
                                     input logic [THR_W-1:0] thr);
        set_threshold(thr);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (n) send_sample(pick_sample());
    endtask

    initial begin
        foreach (win_q[i]) begin
            win_q[i] = '0;
        end
        fill_q = 0;
        held_q = '0;
        thr_q  = THR_RESET;

        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fill();
        test_band_edges();
        test_zero_threshold();
        test_rail_walk();
        test_backpressure();
        test_random_phase(110, 0, 0, THR_W'($urandom_range(4000, 1)));
        test_random_phase(100, 87, 0, 15'd1);
        test_random_phase(150, 0, 87, 15'h7FFF);
        test_random_phase(150, 23, 23, THR_W'($urandom_range(32767)));
        test_random_phase(50, 0, 0, 15'd0);
        test_random_phase(110, 23, 23, THR_RESET);
        test_random_phase(100, 0, 87, 15'd500);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("median_gated_outlier_filter: match");
        end else begin
            $display("median_gated_outlier_filter: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/mgof_pkg.sv
rtl/core/mgof_ctrl.sv
rtl/core/mgof_dp.sv
rtl/core/median_gated_outlier_filter.sv
bench/tb.sv
